/* sv/stsc_pkg.sv */
// Package with the transfer types and the codes of the staged transfer session controller.
`timescale 1ns / 1ps
package stsc_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int WORD_BITS   = 32;
    localparam int CFG_REGS    = 2;
    localparam int CFG_IDX_W   = $clog2(CFG_REGS);

    localparam logic [LENGTH_BITS-1:0] BEGIN_LEN = LENGTH_BITS'(9);
    localparam logic [LENGTH_BITS-1:0] DATA_HDR  = LENGTH_BITS'(5);
    localparam logic [LENGTH_BITS-1:0] CTRL_LEN  = LENGTH_BITS'(1);

    localparam logic [WORD_BITS-1:0] MIN_SIZE_RESET = 32'd1;
    localparam logic [WORD_BITS-1:0] MAX_SIZE_RESET = 32'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE = CFG_IDX_W'(1);

    localparam logic [1:0] FN_MESSAGE    = 2'd0;
    localparam logic [1:0] FN_COMPLETE   = 2'd1;
    localparam logic [1:0] FN_DISCONNECT = 2'd2;
    localparam logic [1:0] FN_TIMEOUT    = 2'd3;

    localparam logic [2:0] MSG_BEGIN  = 3'd0;
    localparam logic [2:0] MSG_DATA   = 3'd1;
    localparam logic [2:0] MSG_COMMIT = 3'd2;
    localparam logic [2:0] MSG_ABORT  = 3'd3;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_BUSY  = 3'd1;
    localparam logic [2:0] PH_READY = 3'd2;
    localparam logic [2:0] PH_RECV  = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;
    localparam logic [2:0] PH_ERR   = 3'd5;

    localparam logic [2:0] ER_NONE       = 3'd0;
    localparam logic [2:0] ER_AUTH       = 3'd1;
    localparam logic [2:0] ER_PROTO      = 3'd2;
    localparam logic [2:0] ER_SIZE       = 3'd3;
    localparam logic [2:0] ER_OFFSET     = 3'd4;
    localparam logic [2:0] ER_INCOMPLETE = 3'd5;
    localparam logic [2:0] ER_STORAGE    = 3'd6;
    localparam logic [2:0] ER_TIMEOUT    = 3'd7;

    localparam logic [2:0] AC_NONE   = 3'd0;
    localparam logic [2:0] AC_BEGIN  = 3'd1;
    localparam logic [2:0] AC_DATA   = 3'd2;
    localparam logic [2:0] AC_COMMIT = 3'd3;
    localparam logic [2:0] AC_ABORT  = 3'd4;

    localparam logic [1:0] OC_OK      = 2'd0;
    localparam logic [1:0] OC_REJECT  = 2'd1;
    localparam logic [1:0] OC_RETRY   = 2'd2;
    localparam logic [1:0] OC_NOTHING = 2'd3;

    typedef struct packed {
        logic [1:0]             func;
        logic                   authorized;
        logic [2:0]             msg_kind;
        logic [LENGTH_BITS-1:0] msg_length;
        logic [WORD_BITS-1:0]   first_word;
        logic [WORD_BITS-1:0]   second_word;
        logic [2:0]             done_kind;
        logic                   done_ok;
        logic [2:0]             done_error;
    } t_in;

    typedef struct packed {
        logic [1:0]             outcome;
        logic [2:0]             action_kind;
        logic [WORD_BITS-1:0]   action_total;
        logic [WORD_BITS-1:0]   action_crc;
        logic [WORD_BITS-1:0]   action_offset;
        logic [LENGTH_BITS-1:0] action_length;
        logic [2:0]             session_state;
        logic [2:0]             session_error;
        logic [WORD_BITS-1:0]   bytes_received;
        logic [WORD_BITS-1:0]   bytes_expected;
    } t_out;

endpackage

/* sv/staged_transfer_session_control_unit.sv */
// Top level of the staged transfer session controller: event checks, session state and result.
`timescale 1ns / 1ps
//  Channel  | Direction | Signals                              | Contents
//  input    | in        | i_in_valid, o_in_stall, i_in_data     | one event (t_in)
//  output   | out       | o_out_valid, i_out_stall, o_out_data  | one result (t_out)
//  config   | in        | i_cfg_wr_en, i_cfg_index, i_cfg_data  | size bound registers
//
// One event is taken per cycle while the output is not stalled; the event is registered in
// the input register and its result in the result register, these being the only stages.
// The session checks and the single 32-bit subtract sit between these two registers.
// Reset is synchronous and active low and returns the session to idle with default bounds.
// A stalled output holds its result, and the input register holds its event behind it.
module staged_transfer_session_control_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  stsc_pkg::t_in                    i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output stsc_pkg::t_out                   o_out_data,
    input  logic                             i_cfg_wr_en,
    input  logic [stsc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [stsc_pkg::WORD_BITS-1:0]   i_cfg_data
);
    import stsc_pkg::*;

    logic [WORD_BITS-1:0]   r_min_size;
    logic [WORD_BITS-1:0]   r_max_size;

    logic                   r_in_valid;
    t_in                    r_in;
    logic                   r_out_valid;
    t_out                   r_out;

    logic [2:0]             r_phase;
    logic [2:0]             r_error;
    logic [2:0]             r_pend_act;
    logic [LENGTH_BITS-1:0] r_pend_cnt;
    logic [WORD_BITS-1:0]   r_recv_cnt;
    logic [WORD_BITS-1:0]   r_exp_total;

    logic [2:0]             n_phase;
    logic [2:0]             n_error;
    logic [2:0]             n_pend_act;
    logic [LENGTH_BITS-1:0] n_pend_cnt;
    logic [WORD_BITS-1:0]   n_recv_cnt;
    logic [WORD_BITS-1:0]   n_exp_total;
    t_out                   n_out;

    logic                   out_free;
    logic                   advance;
    logic                   staged;
    logic                   unfinished;
    logic [LENGTH_BITS-1:0] data_len;
    logic [WORD_BITS-1:0]   margin;
    logic                   rej;
    logic [2:0]             rej_code;
    logic                   rej_abort;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign advance     = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign staged     = (r_phase == PH_READY) || (r_phase == PH_RECV);
    assign unfinished = staged || (r_phase == PH_BUSY) || (r_pend_act != AC_NONE);
    assign data_len   = r_in.msg_length - DATA_HDR;
    assign margin     = r_exp_total - r_recv_cnt;

    always_comb begin
        n_phase     = r_phase;
        n_error     = r_error;
        n_pend_act  = r_pend_act;
        n_pend_cnt  = r_pend_cnt;
        n_recv_cnt  = r_recv_cnt;
        n_exp_total = r_exp_total;
        rej         = 1'b0;
        rej_code    = ER_NONE;
        rej_abort   = 1'b0;

        n_out.outcome       = OC_NOTHING;
        n_out.action_kind   = AC_NONE;
        n_out.action_total  = '0;
        n_out.action_crc    = '0;
        n_out.action_offset = '0;
        n_out.action_length = '0;

        case (r_in.func)
            FN_MESSAGE: begin
                if (!r_in.authorized) begin
                    rej = 1'b1; rej_code = ER_AUTH; rej_abort = staged;
                end else if (r_in.msg_length == '0) begin
                    rej = 1'b1; rej_code = ER_PROTO;
                end else if (r_pend_act != AC_NONE || r_phase == PH_BUSY) begin
                    n_out.outcome = OC_RETRY;
                end else begin
                    case (r_in.msg_kind)
                        MSG_BEGIN: begin
                            if (r_in.msg_length != BEGIN_LEN) begin
                                rej = 1'b1; rej_code = ER_PROTO;
                            end else if (r_in.first_word < r_min_size ||
                                         r_in.first_word > r_max_size) begin
                                rej = 1'b1; rej_code = ER_SIZE;
                            end else if (staged) begin
                                rej = 1'b1; rej_code = ER_PROTO; rej_abort = 1'b1;
                            end else begin
                                n_phase            = PH_BUSY;
                                n_error            = ER_NONE;
                                n_recv_cnt         = '0;
                                n_exp_total        = r_in.first_word;
                                n_pend_act         = AC_BEGIN;
                                n_out.outcome      = OC_OK;
                                n_out.action_kind  = AC_BEGIN;
                                n_out.action_total = r_in.first_word;
                                n_out.action_crc   = r_in.second_word;
                            end
                        end
                        MSG_DATA: begin
                            if (r_in.msg_length <= DATA_HDR || !staged) begin
                                rej = 1'b1; rej_code = ER_PROTO; rej_abort = staged;
                            end else if (r_in.first_word != r_recv_cnt) begin
                                rej = 1'b1; rej_code = ER_OFFSET; rej_abort = 1'b1;
                            end else if (WORD_BITS'(data_len) > margin) begin
                                rej = 1'b1; rej_code = ER_SIZE; rej_abort = 1'b1;
                            end else begin
                                n_pend_act          = AC_DATA;
                                n_pend_cnt          = data_len;
                                n_out.outcome       = OC_OK;
                                n_out.action_kind   = AC_DATA;
                                n_out.action_offset = r_in.first_word;
                                n_out.action_length = data_len;
                            end
                        end
                        MSG_COMMIT: begin
                            if (r_in.msg_length != CTRL_LEN) begin
                                rej = 1'b1; rej_code = ER_PROTO; rej_abort = 1'b1;
                            end else if (!staged) begin
                                rej = 1'b1; rej_code = ER_PROTO;
                            end else if (r_recv_cnt != r_exp_total) begin
                                rej = 1'b1; rej_code = ER_INCOMPLETE; rej_abort = 1'b1;
                            end else begin
                                n_phase           = PH_BUSY;
                                n_pend_act        = AC_COMMIT;
                                n_out.outcome     = OC_OK;
                                n_out.action_kind = AC_COMMIT;
                            end
                        end
                        MSG_ABORT: begin
                            if (r_in.msg_length != CTRL_LEN) begin
                                rej = 1'b1; rej_code = ER_PROTO; rej_abort = 1'b1;
                            end else begin
                                n_phase           = PH_IDLE;
                                n_error           = ER_NONE;
                                n_pend_act        = AC_NONE;
                                n_pend_cnt        = '0;
                                n_recv_cnt        = '0;
                                n_exp_total       = '0;
                                n_out.outcome     = OC_OK;
                                n_out.action_kind = AC_ABORT;
                            end
                        end
                        default: begin
                            rej = 1'b1; rej_code = ER_PROTO; rej_abort = staged;
                        end
                    endcase
                end
            end
            FN_COMPLETE: begin
                if (r_in.done_kind == r_pend_act) begin
                    n_out.outcome = OC_OK;
                    n_pend_act    = AC_NONE;
                    if (!r_in.done_ok) begin
                        n_pend_cnt = '0;
                        n_phase    = PH_ERR;
                        n_error    = (r_in.done_error == ER_NONE) ? ER_STORAGE
                                                                  : r_in.done_error;
                    end else begin
                        n_error = ER_NONE;
                        case (r_in.done_kind)
                            AC_BEGIN: begin
                                n_phase = PH_READY;
                            end
                            AC_DATA: begin
                                n_recv_cnt = r_recv_cnt + WORD_BITS'(r_pend_cnt);
                                n_pend_cnt = '0;
                                n_phase    = PH_RECV;
                            end
                            AC_COMMIT: begin
                                n_phase = PH_DONE;
                            end
                            AC_ABORT: begin
                                n_phase     = PH_IDLE;
                                n_pend_cnt  = '0;
                                n_recv_cnt  = '0;
                                n_exp_total = '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            default: begin
                if (unfinished) begin
                    n_out.outcome     = OC_OK;
                    n_out.action_kind = AC_ABORT;
                    n_pend_act        = AC_NONE;
                    n_pend_cnt        = '0;
                    if (r_in.func == FN_DISCONNECT) begin
                        n_phase     = PH_IDLE;
                        n_error     = ER_NONE;
                        n_recv_cnt  = '0;
                        n_exp_total = '0;
                    end else begin
                        n_phase = PH_ERR;
                        n_error = ER_TIMEOUT;
                    end
                end
            end
        endcase

        if (rej) begin
            n_phase           = PH_ERR;
            n_error           = rej_code;
            n_pend_act        = AC_NONE;
            n_pend_cnt        = '0;
            n_out.outcome     = OC_REJECT;
            n_out.action_kind = rej_abort ? AC_ABORT : AC_NONE;
        end

        n_out.session_state  = n_phase;
        n_out.session_error  = n_error;
        n_out.bytes_received = n_recv_cnt;
        n_out.bytes_expected = n_exp_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_size <= MIN_SIZE_RESET;
            r_max_size <= MAX_SIZE_RESET;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_MIN_SIZE) begin
                r_min_size <= i_cfg_data;
            end
            if (i_cfg_index == CFG_MAX_SIZE) begin
                r_max_size <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_error     <= ER_NONE;
            r_pend_act  <= AC_NONE;
            r_pend_cnt  <= '0;
            r_recv_cnt  <= '0;
            r_exp_total <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_phase     <= n_phase;
                r_error     <= n_error;
                r_pend_act  <= n_pend_act;
                r_pend_cnt  <= n_pend_cnt;
                r_recv_cnt  <= n_recv_cnt;
                r_exp_total <= n_exp_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule
